// ===== rtl/core/cpsd_pkg.sv =====
// Shared types and constants of the control pilot state detector.
package cpsd_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int CAL_W        = 12;
  localparam int DELAY_W      = 8;
  localparam int MV_W         = 16;
  localparam int CNT_W        = 9;
  localparam int FS_W         = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int OUT_W        = 40;

  localparam logic [FS_W-1:0] MV_FULL_SCALE = 12'd3300;
  localparam logic [MV_W-1:0] MV_SAT        = 16'hFFFF;

  localparam logic [CAL_W-1:0]   VREF_CAL_RST     = 12'd1527;
  localparam logic [DELAY_W-1:0] SAMPLE_DELAY_RST = 8'd10;
  localparam logic [MV_W-1:0]    DISC_MIN_RST     = 16'd3087;
  localparam logic [MV_W-1:0]    DISC_MAX_RST     = 16'd3187;
  localparam logic [MV_W-1:0]    CONN_MIN_RST     = 16'd2693;
  localparam logic [MV_W-1:0]    CONN_MAX_RST     = 16'd2793;
  localparam logic [MV_W-1:0]    CHG_MIN_RST      = 16'd2320;
  localparam logic [MV_W-1:0]    CHG_MAX_RST      = 16'd2420;

  typedef enum logic [1:0] {
    MODE_DISC = 2'd0,
    MODE_CONN = 2'd1,
    MODE_CHG  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VREF_CAL     = 3'd0,
    REG_SAMPLE_DELAY = 3'd1,
    REG_DISC_MIN     = 3'd2,
    REG_DISC_MAX     = 3'd3,
    REG_CONN_MIN     = 3'd4,
    REG_CONN_MAX     = 3'd5,
    REG_CHG_MIN      = 3'd6,
    REG_CHG_MAX      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

// ===== rtl/core/control_pilot_state_detector.sv =====
// Control pilot state detector top level: tick handling, sampling and mode windows.
// Each beat on the input is one pilot PWM phase tick. A tick that does not sample the
// ADC goes straight to ST_FINISH and its result is registered once the output slot is
// free. A sampling tick runs the serial millivolt converter, one bit per cycle:
// shift-add multiply, then restoring division of the ADC_BITS+24 bit numerator.
// The next tick is accepted once the current one has moved into the output register;
// a waiting result does not hold off the next tick. The configuration port is always
// ready and should only be written while no tick is in flight.
module control_pilot_state_detector #(
  parameter int ADC_BITS = cpsd_pkg::ADC_BITS_DEF,
  localparam int IN_W = ((2 * ADC_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input ticks.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,  // pilot_code, ref_code, zero pad
  input  logic [0:0]                      s_axis_tuser,  // operation
  // Results.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pilot_level, low_timer_start, low_timer_stop, sample_taken, high_voltage_mv,
  // low_voltage_mv, vehicle_mode, zero pad
  output logic [cpsd_pkg::OUT_W-1:0]      m_axis_tdata,
  // Configuration writes.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cpsd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MV_W  = cpsd_pkg::MV_W;
  localparam int CNT_W = cpsd_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CONV   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state;

  logic [cpsd_pkg::CAL_W-1:0]   vref_cal;
  logic [cpsd_pkg::DELAY_W-1:0] sample_delay;
  logic [MV_W-1:0] disc_min, disc_max, conn_min, conn_max, chg_min, chg_max;

  cpsd_pkg::mode_t mode, mode_next;
  logic [CNT_W-1:0] high_cnt, high_cnt_next, low_cnt, low_cnt_next;
  logic [MV_W-1:0]  high_mv, high_mv_next, low_mv, low_mv_next;

  logic op;
  logic sample;

  logic                 accept;
  logic                 sample_now;
  logic                 conv_start;
  logic                 slot_free;
  logic                 finish;
  cpsd_pkg::conv_stat_t conv_stat;
  logic [MV_W-1:0]      conv_mv;

  logic                 in_disc, in_conn, in_chg;
  logic [cpsd_pkg::OUT_W-1:0] out_data_next;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign sample_now    = s_axis_tuser[0] ? (low_cnt > CNT_W'(sample_delay))
                                         : (high_cnt > CNT_W'(sample_delay));
  assign conv_start    = accept && sample_now;
  assign slot_free     = !m_axis_tvalid || m_axis_tready;
  assign finish        = (state == ST_FINISH) && slot_free;

  cpsd_mv_conv #(
    .ADC_BITS (ADC_BITS)
  ) u_conv (
    .clk        (clk),
    .rst        (rst),
    .start      (conv_start),
    .pilot_code (s_axis_tdata[ADC_BITS-1:0]),
    .ref_code   (s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
    .vref_cal   (vref_cal),
    .status     (conv_stat),
    .mv         (conv_mv)
  );

  // Update of the stored voltages, counters and mode when a tick completes.
  always_comb begin
    high_mv_next  = high_mv;
    low_mv_next   = low_mv;
    high_cnt_next = high_cnt;
    low_cnt_next  = low_cnt;
    mode_next     = mode;
    if (!op) begin
      if (sample) begin
        high_mv_next  = conv_mv;
        high_cnt_next = '0;
      end else begin
        high_cnt_next = high_cnt + 1'b1;
      end
    end else begin
      if (sample) begin
        low_mv_next  = conv_mv;
        low_cnt_next = '0;
      end else begin
        low_cnt_next = low_cnt + 1'b1;
      end
    end
    in_disc = (high_mv_next >= disc_min) && (high_mv_next <= disc_max);
    in_conn = (high_mv_next >= conn_min) && (high_mv_next <= conn_max);
    in_chg  = (high_mv_next >= chg_min) && (high_mv_next <= chg_max);
    // High-phase ticks check the windows in priority order; no match keeps the mode.
    if (!op) begin
      if (in_disc) begin
        mode_next = cpsd_pkg::MODE_DISC;
      end else if (in_conn) begin
        mode_next = cpsd_pkg::MODE_CONN;
      end else if (in_chg) begin
        mode_next = cpsd_pkg::MODE_CHG;
      end
    end
    out_data_next = {2'b00, mode_next, low_mv_next, high_mv_next, sample, op,
                     !op && (mode != cpsd_pkg::MODE_DISC), !op};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      mode          <= cpsd_pkg::MODE_DISC;
      high_cnt      <= '0;
      low_cnt       <= '0;
      high_mv       <= '0;
      low_mv        <= '0;
    end else begin
      if (finish) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= sample_now ? ST_CONV : ST_FINISH;
          end
        end
        ST_CONV: begin
          if (conv_stat.done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            state         <= ST_IDLE;
            mode          <= mode_next;
            high_cnt      <= high_cnt_next;
            low_cnt       <= low_cnt_next;
            high_mv       <= high_mv_next;
            low_mv        <= low_mv_next;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op     <= s_axis_tuser[0];
      sample <= sample_now;
    end
    if (finish) begin
      m_axis_tdata <= out_data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vref_cal     <= cpsd_pkg::VREF_CAL_RST;
      sample_delay <= cpsd_pkg::SAMPLE_DELAY_RST;
      disc_min     <= cpsd_pkg::DISC_MIN_RST;
      disc_max     <= cpsd_pkg::DISC_MAX_RST;
      conn_min     <= cpsd_pkg::CONN_MIN_RST;
      conn_max     <= cpsd_pkg::CONN_MAX_RST;
      chg_min      <= cpsd_pkg::CHG_MIN_RST;
      chg_max      <= cpsd_pkg::CHG_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cpsd_pkg::reg_idx_t'(cfg_index))
        cpsd_pkg::REG_VREF_CAL:     vref_cal     <= cfg_data[cpsd_pkg::CAL_W-1:0];
        cpsd_pkg::REG_SAMPLE_DELAY: sample_delay <= cfg_data[cpsd_pkg::DELAY_W-1:0];
        cpsd_pkg::REG_DISC_MIN:     disc_min     <= cfg_data;
        cpsd_pkg::REG_DISC_MAX:     disc_max     <= cfg_data;
        cpsd_pkg::REG_CONN_MIN:     conn_min     <= cfg_data;
        cpsd_pkg::REG_CONN_MAX:     conn_max     <= cfg_data;
        cpsd_pkg::REG_CHG_MIN:      chg_min      <= cfg_data;
        cpsd_pkg::REG_CHG_MAX:      chg_max      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A sampling tick must find the converter free and keep it busy until done.
  a_conv_free_on_start: assert property (@(posedge clk) disable iff (rst)
    conv_start |-> !conv_stat.busy)
    else $error("conversion started while converter busy");

  a_conv_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (conv_stat.busy || conv_stat.done))
    else $error("waiting on a converter that is not running");

  // Counters never pass one above the largest delay.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (high_cnt <= 9'd256) && (low_cnt <= 9'd256))
    else $error("decimation counter out of range");

  // A completed sampling tick clears the counter of its phase.
  a_sample_clears: assert property (@(posedge clk) disable iff (rst)
    (finish && sample) |=> m_axis_tdata[3] &&
                           (m_axis_tdata[0] ? (high_cnt == '0) : (low_cnt == '0)))
    else $error("sample did not clear its counter");

  // Only one tick is in flight: after acceptance the input side closes.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("second tick accepted while busy");

endmodule

// ===== rtl/core/cpsd_mv_conv.sv =====
// Bit-serial millivolt converter: shift-add multiply, then restoring division.
module cpsd_mv_conv #(
  parameter int ADC_BITS = cpsd_pkg::ADC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ADC_BITS-1:0]          pilot_code,
  input  logic [ADC_BITS-1:0]          ref_code,
  input  logic [cpsd_pkg::CAL_W-1:0]   vref_cal,
  output cpsd_pkg::conv_stat_t         status,
  output logic [cpsd_pkg::MV_W-1:0]    mv
);

  localparam int KW = cpsd_pkg::CAL_W + cpsd_pkg::FS_W;
  localparam int NW = KW + ADC_BITS;
  localparam int DW = 2 * ADC_BITS;
  localparam int CW = $clog2(NW);
  localparam int QW = cpsd_pkg::MV_W;

  typedef enum logic [2:0] {
    CV_IDLE = 3'b001,
    CV_MUL  = 3'b010,
    CV_DIV  = 3'b100
  } cv_state_t;

  cv_state_t           state;
  logic                done;
  logic [CW-1:0]       cnt;
  logic [KW-1:0]       k;
  logic [ADC_BITS-1:0] pil;
  logic [DW-1:0]       den;
  logic [NW-1:0]       acc;
  logic [DW-1:0]       rem;
  logic [QW-1:0]       q;
  logic                ovf;

  logic [DW:0]         rem_sh;
  logic                q_bit;

  // One quotient bit per cycle; the numerator leaves acc MSB first.
  assign rem_sh = {rem, acc[NW-1]};
  assign q_bit  = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CV_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        CV_IDLE: begin
          if (start) begin
            state <= CV_MUL;
          end
        end
        CV_MUL: begin
          if (cnt == '0) begin
            state <= CV_DIV;
          end
        end
        CV_DIV: begin
          if (cnt == '0) begin
            state <= CV_IDLE;
            done  <= 1'b1;
          end
        end
        default: begin
          state <= CV_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CV_IDLE: begin
        if (start) begin
          k   <= KW'(vref_cal) * KW'(cpsd_pkg::MV_FULL_SCALE);
          pil <= pilot_code;
          // ref * (2^ADC_BITS - 1) without a multiplier.
          den <= DW'({ref_code, {ADC_BITS{1'b0}}}) - DW'(ref_code);
          acc <= '0;
          cnt <= CW'(ADC_BITS - 1);
        end
      end
      CV_MUL: begin
        acc <= (acc << 1) + (pil[ADC_BITS-1] ? NW'(k) : '0);
        pil <= pil << 1;
        if (cnt == '0) begin
          cnt <= CW'(NW - 1);
          rem <= '0;
          q   <= '0;
          ovf <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      CV_DIV: begin
        // A zero reference gives all ones quotient bits, which saturates below.
        rem <= q_bit ? DW'(rem_sh - {1'b0, den}) : DW'(rem_sh);
        acc <= acc << 1;
        q   <= {q[QW-2:0], q_bit};
        ovf <= ovf | q[QW-1];
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign status.busy = (state != CV_IDLE);
  assign status.done = done;
  assign mv          = ovf ? cpsd_pkg::MV_SAT : q;

endmodule

// ===== tb/tb_control_pilot_state_detector.sv =====
// Self-checking testbench for the control pilot state detector.
`timescale 1ns / 1ps

module tb_control_pilot_state_detector;
  import cpsd_pkg::*;

  localparam int ADC_W        = ADC_BITS_DEF;
  localparam int IN_W         = ((2 * ADC_W + 7) / 8) * 8;
  localparam longint unsigned ADC_FULL = (64'd1 << ADC_W) - 1;
  localparam int DRAIN_CYCLES = 2 * ADC_W + 36;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1_000_000;

  localparam logic OP_HIGH = 1'b0;
  localparam logic OP_LOW  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [ADC_W-1:0] pilot;
    logic [ADC_W-1:0] refc;
  } tick_t;

  typedef struct packed {
    logic            level;
    logic            start;
    logic            stop;
    logic            taken;
    logic [MV_W-1:0] high_mv;
    logic [MV_W-1:0] low_mv;
    logic [1:0]      mode;
  } result_t;

  typedef struct {
    logic [CAL_W-1:0]   vref_cal;
    logic [DELAY_W-1:0] sample_delay;
    logic [MV_W-1:0]    win_lo [3];
    logic [MV_W-1:0]    win_hi [3];
  } cfg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Predictor state and the register copy it works from.
  cfg_t            cur_cfg;
  mode_t           det_mode = MODE_DISC;
  logic [CNT_W-1:0] high_cnt = '0;
  logic [CNT_W-1:0] low_cnt  = '0;
  logic [MV_W-1:0]  high_mv  = '0;
  logic [MV_W-1:0]  low_mv   = '0;

  result_t pending_results [$];
  int      mismatch_cnt = 0;
  int      cycle_cnt    = 0;
  int      burst_left   = 0;
  logic    next_op      = OP_HIGH;

  // Receiver stall control; the hold request is a token the receiver picks up.
  int hold_req_cnt  = 0;
  int hold_seen_cnt = 0;
  int hold_left     = 0;
  int stall_style   = 0;
  int style_left    = 0;

  control_pilot_state_detector dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // pilot_code, ref_code, zero pad
    .s_axis_tuser  (s_axis_tuser),   // operation
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // pilot_level, low_timer_start, low_timer_stop, sample_taken, high_voltage_mv,
    // low_voltage_mv, vehicle_mode, zero pad
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [MV_W-1:0] pilot_mv(logic [ADC_W-1:0] pilot, logic [ADC_W-1:0] refc);
    longint unsigned num, den, q;
    if (refc == 0) return MV_SAT;
    num = 64'(MV_FULL_SCALE) * 64'(cur_cfg.vref_cal) * 64'(pilot);
    den = 64'(refc) * ADC_FULL;
    q   = num / den;
    return (q > 64'(MV_SAT)) ? MV_SAT : q[MV_W-1:0];
  endfunction

  function automatic bit in_window(logic [MV_W-1:0] v, mode_t w);
    return v >= cur_cfg.win_lo[w] && v <= cur_cfg.win_hi[w];
  endfunction

  function automatic result_t advance_detector(tick_t t);
    result_t r;
    r = '0;
    if (t.op == OP_HIGH) begin
      r.level = 1'b1;
      // The start request looks at the mode from before this tick.
      r.start = (det_mode != MODE_DISC);
      if (high_cnt > cur_cfg.sample_delay) begin
        high_mv  = pilot_mv(t.pilot, t.refc);
        high_cnt = '0;
        r.taken  = 1'b1;
      end else begin
        high_cnt = high_cnt + 1'b1;
      end
      if (in_window(high_mv, MODE_DISC)) begin
        det_mode = MODE_DISC;
      end else if (in_window(high_mv, MODE_CONN)) begin
        det_mode = MODE_CONN;
      end else if (in_window(high_mv, MODE_CHG)) begin
        det_mode = MODE_CHG;
      end
    end else begin
      r.stop = 1'b1;
      if (low_cnt > cur_cfg.sample_delay) begin
        low_mv  = pilot_mv(t.pilot, t.refc);
        low_cnt = '0;
        r.taken = 1'b1;
      end else begin
        low_cnt = low_cnt + 1'b1;
      end
    end
    r.high_mv = high_mv;
    r.low_mv  = low_mv;
    r.mode    = det_mode;
    return r;
  endfunction

  function automatic tick_t mk_tick(logic op, int unsigned pilot, int unsigned refc);
    tick_t t;
    t.op    = op;
    t.pilot = ADC_W'(pilot);
    t.refc  = ADC_W'(refc);
    return t;
  endfunction

  // Pick a pilot code that lands near the target voltage for the given reference code.
  function automatic logic [ADC_W-1:0] pilot_for_mv(int unsigned target, logic [ADC_W-1:0] refc);
    longint unsigned den, p;
    den = 64'(MV_FULL_SCALE) * 64'(cur_cfg.vref_cal);
    if (den == 0 || refc == 0) return ADC_W'($urandom);
    p = (64'(target) * 64'(refc) * ADC_FULL + den - 1) / den;
    return (p > ADC_FULL) ? ADC_W'(ADC_FULL) : p[ADC_W-1:0];
  endfunction

  function automatic cfg_t reset_cfg();
    cfg_t c;
    c.vref_cal          = VREF_CAL_RST;
    c.sample_delay      = SAMPLE_DELAY_RST;
    c.win_lo[MODE_DISC] = DISC_MIN_RST;
    c.win_hi[MODE_DISC] = DISC_MAX_RST;
    c.win_lo[MODE_CONN] = CONN_MIN_RST;
    c.win_hi[MODE_CONN] = CONN_MAX_RST;
    c.win_lo[MODE_CHG]  = CHG_MIN_RST;
    c.win_hi[MODE_CHG]  = CHG_MAX_RST;
    return c;
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    int unsigned lo, hi, tmp;
    c.vref_cal = ($urandom_range(0, 7) == 0) ? CAL_W'(4095) : CAL_W'($urandom_range(200, 4095));
    c.sample_delay = ($urandom_range(0, 5) == 0) ? DELAY_W'($urandom_range(4, 20))
                                                 : DELAY_W'($urandom_range(0, 3));
    foreach (c.win_lo[k]) begin
      lo = $urandom_range(0, 4000);
      hi = lo + $urandom_range(0, 600);
      case ($urandom_range(0, 15))
        0: lo = 0;
        1: hi = 65535;
        2: begin
          tmp = lo;
          lo  = hi + 1;
          hi  = tmp;
        end
        3: begin
          lo = $urandom_range(0, 65535);
          hi = 65535;
        end
        default: ;
      endcase
      c.win_lo[k] = MV_W'(lo);
      c.win_hi[k] = MV_W'(hi);
    end
    return c;
  endfunction

  function automatic void field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $display("%0t unexpected result beat: expected none actual %h", $time, m_axis_tdata);
      mismatch_cnt++;
    end else begin
      want = pending_results.pop_front();
      field_check("pilot_level", want.level, m_axis_tdata[0]);
      field_check("low_timer_start", want.start, m_axis_tdata[1]);
      field_check("low_timer_stop", want.stop, m_axis_tdata[2]);
      field_check("sample_taken", want.taken, m_axis_tdata[3]);
      field_check("high_voltage_mv", want.high_mv, m_axis_tdata[19:4]);
      field_check("low_voltage_mv", want.low_mv, m_axis_tdata[35:20]);
      field_check("vehicle_mode", want.mode, m_axis_tdata[37:36]);
    end
  endtask

  // Result side: check each beat, then pick the next ready value.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (hold_seen_cnt != hold_req_cnt) begin
        hold_seen_cnt = hold_req_cnt;
        hold_left     = HOLD_CYCLES;
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(20, 300);
      end else begin
        style_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_style)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 3) != 0);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ((style_left % 32) < 12);
        endcase
      end
    end
  end

  task automatic send_tick(tick_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({t.refc, t.pilot});
    s_axis_tuser  <= t.op;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    pending_results.push_back(advance_detector(t));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_VREF_CAL:     cur_cfg.vref_cal          = val[CAL_W-1:0];
      REG_SAMPLE_DELAY: cur_cfg.sample_delay      = val[DELAY_W-1:0];
      REG_DISC_MIN:     cur_cfg.win_lo[MODE_DISC] = val;
      REG_DISC_MAX:     cur_cfg.win_hi[MODE_DISC] = val;
      REG_CONN_MIN:     cur_cfg.win_lo[MODE_CONN] = val;
      REG_CONN_MAX:     cur_cfg.win_hi[MODE_CONN] = val;
      REG_CHG_MIN:      cur_cfg.win_lo[MODE_CHG]  = val;
      REG_CHG_MAX:      cur_cfg.win_hi[MODE_CHG]  = val;
      default: ;
    endcase
  endtask

  task automatic apply_cfg(cfg_t c);
    wait_idle();
    write_reg(REG_VREF_CAL, CFG_DATA_W'(c.vref_cal));
    write_reg(REG_SAMPLE_DELAY, CFG_DATA_W'(c.sample_delay));
    write_reg(REG_DISC_MIN, c.win_lo[MODE_DISC]);
    write_reg(REG_DISC_MAX, c.win_hi[MODE_DISC]);
    write_reg(REG_CONN_MIN, c.win_lo[MODE_CONN]);
    write_reg(REG_CONN_MAX, c.win_hi[MODE_CONN]);
    write_reg(REG_CHG_MIN, c.win_lo[MODE_CHG]);
    write_reg(REG_CHG_MAX, c.win_hi[MODE_CHG]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Zero and full-scale codes, zero reference and a voltage too large for 16 bits.
  task automatic test_field_extremes();
    cfg_t c;
    c = cur_cfg;
    c.vref_cal     = CAL_W'(4095);
    c.sample_delay = '0;
    apply_cfg(c);
    send_tick(mk_tick(OP_HIGH, 0, 0));
    send_tick(mk_tick(OP_HIGH, 4095, 0));
    send_tick(mk_tick(OP_LOW, 0, 4095));
    send_tick(mk_tick(OP_LOW, 4095, 1));
    send_tick(mk_tick(OP_HIGH, 0, 4095));
    send_tick(mk_tick(OP_HIGH, 0, 4095));
    send_tick(mk_tick(OP_LOW, 4095, 4095));
    send_tick(mk_tick(OP_LOW, 4095, 4095));
  endtask

  // With full calibration and a reference code of 3300 the voltage equals the pilot code.
  // Ticks go in pairs so that exactly one of each pair samples.
  task automatic test_window_priority();
    cfg_t c;
    int unsigned levels [3] = '{1800, 2200, 2950};
    c = cur_cfg;
    c.vref_cal          = CAL_W'(4095);
    c.sample_delay      = '0;
    c.win_lo[MODE_DISC] = 16'd1000;
    c.win_hi[MODE_DISC] = 16'd2000;
    c.win_lo[MODE_CONN] = 16'd1500;
    c.win_hi[MODE_CONN] = 16'd2500;
    // Empty charging window: nothing matches 2950 and the mode is kept.
    c.win_lo[MODE_CHG]  = 16'd3000;
    c.win_hi[MODE_CHG]  = 16'd2900;
    apply_cfg(c);
    foreach (levels[k]) begin
      send_tick(mk_tick(OP_HIGH, levels[k], 3300));
      send_tick(mk_tick(OP_HIGH, levels[k], 3300));
    end
    c.win_lo[MODE_CHG] = 16'd2900;
    c.win_hi[MODE_CHG] = 16'd3000;
    apply_cfg(c);
    send_tick(mk_tick(OP_HIGH, 2950, 3300));
    send_tick(mk_tick(OP_HIGH, 2950, 3300));
    send_tick(mk_tick(OP_HIGH, 1000, 3300));
    send_tick(mk_tick(OP_HIGH, 1000, 3300));
  endtask

  // Lowering the delay below a running count makes the next tick of that phase sample.
  task automatic test_delay_lowered();
    cfg_t c;
    c = cur_cfg;
    c.sample_delay = 8'd200;
    apply_cfg(c);
    repeat (5) send_tick(mk_tick(OP_HIGH, 2200, 3300));
    c.sample_delay = 8'd2;
    apply_cfg(c);
    send_tick(mk_tick(OP_HIGH, 1800, 3300));
  endtask

  task automatic test_random_traffic(int n, bit mostly_high);
    tick_t       t;
    int          i;
    int unsigned target;
    mode_t       w;
    for (i = 0; i < n; i++) begin
      if (mostly_high) begin
        t.op = ($urandom_range(0, 19) == 0) ? OP_LOW : OP_HIGH;
      end else if ($urandom_range(0, 9) == 0) begin
        t.op = 1'($urandom_range(0, 1));
      end else begin
        t.op = next_op;
      end
      next_op = (t.op == OP_HIGH) ? OP_LOW : OP_HIGH;
      case ($urandom_range(0, 19))
        0: t.refc = '0;
        1: t.refc = ADC_W'(ADC_FULL);
        default: t.refc = ADC_W'($urandom_range(1, ADC_FULL));
      endcase
      if ($urandom_range(0, 9) < 7) begin
        // Aim at one of the windows so that every mode is reached.
        w = mode_t'($urandom_range(0, 2));
        if (cur_cfg.win_lo[w] <= cur_cfg.win_hi[w]) begin
          target = $urandom_range(cur_cfg.win_lo[w], cur_cfg.win_hi[w]);
        end else begin
          target = $urandom_range(0, 4000);
        end
        t.pilot = pilot_for_mv(target, t.refc);
      end else begin
        t.pilot = ADC_W'($urandom);
      end
      send_tick(t);
    end
  endtask

  // The receiver holds off for a long stretch while ticks keep coming.
  task automatic test_output_backpressure();
    apply_cfg(random_cfg());
    hold_req_cnt <= hold_req_cnt + 1;
    burst_left = 40;
    test_random_traffic(40, 1'b0);
  endtask

  task automatic test_extreme_settings();
    cfg_t c;
    c.vref_cal     = '0;
    c.sample_delay = '0;
    foreach (c.win_lo[k]) begin
      c.win_lo[k] = '0;
      c.win_hi[k] = '0;
    end
    apply_cfg(c);
    test_random_traffic(40, 1'b0);
    c.vref_cal     = CAL_W'(4095);
    c.sample_delay = DELAY_W'(255);
    foreach (c.win_lo[k]) begin
      c.win_lo[k] = MV_SAT;
      c.win_hi[k] = MV_SAT;
    end
    apply_cfg(c);
    // The tick count has to pass 255 before a high-phase sample is taken.
    test_random_traffic(280, 1'b1);
  endtask

  initial begin
    cur_cfg = reset_cfg();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_window_priority();
    test_delay_lowered();
    apply_cfg(reset_cfg());
    test_random_traffic(250, 1'b0);
    repeat (5) begin
      apply_cfg(random_cfg());
      test_random_traffic(180, 1'b0);
    end
    test_output_backpressure();
    test_extreme_settings();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
